// ===== design/ppz_pkg.sv =====
// Shared types and constants for the point projection z-buffer plotter.
// No dependencies.
package ppz_pkg;
  localparam logic OP_PLOT = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] FACE_BACK   = 3'd0;
  localparam logic [2:0] FACE_FRONT  = 3'd1;
  localparam logic [2:0] FACE_RIGHT  = 3'd2;
  localparam logic [2:0] FACE_LEFT   = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;

  localparam logic [2:0] REG_SIN_A = 3'd0;
  localparam logic [2:0] REG_COS_A = 3'd1;
  localparam logic [2:0] REG_SIN_B = 3'd2;
  localparam logic [2:0] REG_COS_B = 3'd3;
  localparam logic [2:0] REG_SCALE = 3'd4;
  localparam logic [2:0] REG_EYE   = 3'd5;
  localparam logic [2:0] REG_OFF_X = 3'd6;
  localparam logic [2:0] REG_OFF_Y = 3'd7;

  localparam logic [1:0] COLOUR_BLANK = 2'd0;
  localparam logic [1:0] COLOUR_GREEN = 2'd1;
  localparam logic [1:0] COLOUR_GREY  = 2'd2;

  localparam logic [3:0] GLYPH_MAX = 4'd11;

  // Work handed from the front end to the cell update stage.
  typedef struct packed {
    logic       is_read;
    logic       live;      // plot survived lighting, depth, clip
    logic [8:0] col;
    logic [8:0] row;
    logic [15:0] ooz;
    logic [3:0] glyph;
    logic [1:0] colour;
  } ppz_cmd_t;
endpackage

// ===== design/ppz_front.sv =====
// Front end: lighting, rotation, reciprocal depth and projection of one word.
// Depends on ppz_pkg.
module ppz_front import ppz_pkg::*; #(
  parameter int SCREEN_COLS = 120,
  parameter int SCREEN_ROWS = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [2:0]  face,
  input  logic signed [15:0] coord_u,
  input  logic signed [15:0] coord_v,
  input  logic signed [15:0] coord_w,
  input  logic        dark,
  input  logic [6:0]  cell_col,
  input  logic [5:0]  cell_row,
  input  logic signed [15:0] sin_a,
  input  logic signed [15:0] cos_a,
  input  logic signed [15:0] sin_b,
  input  logic signed [15:0] cos_b,
  input  logic [7:0]  scale_factor,
  input  logic [7:0]  eye_distance,
  input  logic [7:0]  offset_x,
  input  logic [7:0]  offset_y,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output ppz_cmd_t    cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_LIT, S_ROT1, S_ROT2, S_ROT3, S_DEN, S_DIV, S_PROJ1, S_PROJ2, S_PROJ3,
    S_DONE
  } state_t;

  state_t state;
  logic        face_bad;
  logic [2:0]  fc;
  logic        dk;
  logic signed [15:0] pu, pv, pw;
  logic signed [31:0] lit;
  logic signed [33:0] x22, s22;
  logic signed [15:0] rv;       // coordinate that goes with cos_b*2^14
  logic signed [50:0] yt, zt;
  logic signed [37:0] y22, z22;
  logic signed [38:0] den;
  logic [38:0] rem;
  logic [38:0] quo;
  logic [5:0]  cnt;
  logic [15:0] ooz;
  logic [23:0] ko;              // K1 * ooz
  logic signed [60:0] ax, ay;   // products before the offsets are added
  logic signed [60:0] pxs, pys;
  logic [3:0] glyph;

  // Per-face operand choice
  logic signed [15:0] ma, mb, mc;  // x = ma*ca + mb*sa-ish arranged below
  always_comb begin
    ma = pu; mb = pw; mc = pv;
    unique case (fc)
      FACE_BACK, FACE_FRONT: begin ma = pu; mb = pw;  mc = pv; end
      FACE_RIGHT, FACE_LEFT: begin ma = pw; mb = pv;  mc = pu; end
      default:               begin ma = pu; mb = pv;  mc = pw; end
    endcase
  end
  // Faces 0/1: x = u*ca + w*sa, s = u*sa - w*ca.
  // Others:    x = ma*ca - mb*sa, s = ma*sa + mb*ca.

  logic signed [63:0] glyph_prod;
  assign glyph_prod = 64'(lit) * 64'sd11;

  logic [39:0] rem_sh;
  assign rem_sh = {rem, quo[38]};

  logic signed [40:0] bound_x, bound_y;
  logic signed [60:0] tx, ty;
  // truncation toward zero of value/2^38
  assign tx = pxs;
  assign ty = pys;
  logic signed [22:0] qx, qy;
  assign qx = (tx < 0) ? -23'(((-tx) >>> 38)) : 23'(tx >>> 38);
  assign qy = (ty < 0) ? -23'(((-ty) >>> 38)) : 23'(ty >>> 38);
  assign bound_x = 41'(qx);
  assign bound_y = 41'(qy);

  assign in_ready = (state == S_IDLE) && !cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) cmd_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          pu <= coord_u; pv <= coord_v; pw <= coord_w;
          fc <= face; dk <= dark;
          face_bad <= (face > FACE_BOTTOM);
          if (op == OP_READ) begin
            cmd.is_read <= 1'b1; cmd.live <= 1'b0;
            cmd.col <= 9'(cell_col); cmd.row <= 9'(cell_row);
            cmd.ooz <= '0; cmd.glyph <= '0; cmd.colour <= COLOUR_BLANK;
            cmd_valid <= 1'b1;
          end else begin
            state <= S_LIT;
          end
        end
        S_LIT: begin
          unique case (fc)
            FACE_BACK:   lit <= -(32'(cos_a) * 32'(cos_b));
            FACE_FRONT:  lit <= 32'(cos_a) * 32'(cos_b);
            FACE_RIGHT:  lit <= -(32'(sin_a) * 32'(cos_b));
            FACE_LEFT:   lit <= 32'(sin_a) * 32'(cos_b);
            FACE_TOP:    lit <= 32'(sin_b) <<< 14;
            FACE_BOTTOM: lit <= -(32'(sin_b) <<< 14);
            default:     lit <= '0;
          endcase
          state <= S_ROT1;
        end
        S_ROT1: begin
          if (fc <= FACE_FRONT) begin
            x22 <= 34'(ma) * 34'(cos_a) + 34'(mb) * 34'(sin_a);
            s22 <= 34'(ma) * 34'(sin_a) - 34'(mb) * 34'(cos_a);
          end else begin
            x22 <= 34'(ma) * 34'(cos_a) - 34'(mb) * 34'(sin_a);
            s22 <= 34'(ma) * 34'(sin_a) + 34'(mb) * 34'(cos_a);
          end
          rv <= mc;
          if (glyph_prod[63:28] > 36'(GLYPH_MAX)) glyph <= GLYPH_MAX;
          else glyph <= glyph_prod[31:28];
          state <= S_ROT2;
        end
        S_ROT2: begin
          yt <= 51'(s22) * 51'(sin_b);
          zt <= 51'(s22) * 51'(cos_b);
          state <= S_ROT3;
        end
        S_ROT3: begin
          y22 <= 38'((yt + ((51'(rv) * 51'(cos_b)) <<< 14)) >>> 14);
          z22 <= 38'((zt - ((51'(rv) * 51'(sin_b)) <<< 14)) >>> 14);
          state <= S_DEN;
        end
        S_DEN: begin
          den <= 39'(z22) + (39'(eye_distance) <<< 22);
          rem <= '0;
          quo <= 39'(1) <<< 38;
          cnt <= 6'd39;
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring divider, one quotient bit a cycle
          if (face_bad || lit <= 0 || den <= 0) begin
            state <= S_DONE;
          end else begin
            if (rem_sh >= 40'(den)) begin
              rem <= 39'(rem_sh - 40'(den));
              quo <= {quo[37:0], 1'b1};
            end else begin
              rem <= 39'(rem_sh);
              quo <= {quo[37:0], 1'b0};
            end
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) state <= S_PROJ1;
          end
        end
        S_PROJ1: begin
          ooz <= (quo > 39'hFFFF) ? 16'hFFFF : quo[15:0];
          state <= S_PROJ2;
        end
        S_PROJ2: begin
          ko <= 24'(scale_factor) * 24'(ooz);
          state <= S_PROJ3;
        end
        S_PROJ3: begin
          ax <= 61'(signed'({1'b0, ko})) * 61'(x22);
          ay <= 61'(signed'({1'b0, ko})) * 61'(y22);
          state <= S_DONE;
        end
        S_DONE: if (!cmd_valid) begin
          cmd.is_read <= 1'b0;
          cmd.ooz <= ooz; cmd.glyph <= glyph;
          cmd.colour <= dk ? COLOUR_GREY : COLOUR_GREEN;
          cmd.col <= 9'(bound_x); cmd.row <= 9'(bound_y);
          cmd.live <= !(face_bad || lit <= 0 || den <= 0) && bound_x >= 0 &&
                      bound_x < 41'(SCREEN_COLS) && bound_y >= 0 &&
                      bound_y < 41'(SCREEN_ROWS);
          cmd_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // add offsets once products are registered
  always_comb begin
    pxs = ax + (61'(offset_x) <<< 38);
    pys = ay + (61'(offset_y) <<< 38);
  end

`ifndef SYNTHESIS
  a_no_double_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid) else $error("cmd dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready out of idle");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt != 6'd0) else $error("divider overrun");
`endif
endmodule

// ===== design/ppz_queue.sv =====
// Two-entry queue between front end and cell update stage.
// Depends on ppz_pkg.
module ppz_queue import ppz_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ppz_cmd_t in_cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output ppz_cmd_t out_cmd
);
  ppz_cmd_t slot [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_cmd   = slot[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slot[wp] <= in_cmd;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !(in_valid && in_ready) |=> cnt == $past(cnt))
    else $error("queue count moved");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd0 |-> wp == rp) else $error("pointer skew");
`endif
endmodule

// ===== design/ppz_back.sv =====
// Back end: depth test and read-and-clear on the cell memory, with clearing sweep.
// Depends on ppz_pkg.
module ppz_back import ppz_pkg::*; #(
  parameter int SCREEN_COLS = 120,
  parameter int SCREEN_ROWS = 60
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  ppz_cmd_t cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     written,
  output logic [6:0] pixel_col,
  output logic [5:0] pixel_row,
  output logic [3:0] glyph,
  output logic [1:0] colour
);
  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW = $clog2(CELLS);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;
  state_t state;

  logic [21:0] mem [CELLS];   // {pixel[5:0], depth[15:0]}
  logic [21:0] rd;
  logic [AW-1:0] addr, sweep;
  ppz_cmd_t    cur;
  logic        in_grid;

  assign in_grid = cmd.col < 9'(SCREEN_COLS) && cmd.row < 9'(SCREEN_ROWS);
  assign cmd_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) mem[sweep] <= '0;
    else if (state == S_WRITE) begin
      if (cur.is_read) mem[addr] <= '0;
      else if (cur.ooz > rd[15:0]) mem[addr] <= {cur.colour, cur.glyph, cur.ooz};
    end
    rd <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd_valid && cmd_ready) begin
          cur <= cmd;
          addr <= AW'(cmd.row) * AW'(SCREEN_COLS) + AW'(cmd.col);
          if (cmd.is_read && !in_grid) begin
            written <= 1'b0; pixel_col <= 7'(cmd.col); pixel_row <= 6'(cmd.row);
            glyph <= '0; colour <= COLOUR_BLANK; out_valid <= 1'b1;
          end else if (!cmd.is_read && !cmd.live) begin
            written <= 1'b0; pixel_col <= '0; pixel_row <= '0;
            glyph <= '0; colour <= COLOUR_BLANK; out_valid <= 1'b1;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          pixel_col <= 7'(cur.col); pixel_row <= 6'(cur.row);
          if (cur.is_read) begin
            written <= 1'b0; glyph <= rd[19:16]; colour <= rd[21:20];
          end else if (cur.ooz > rd[15:0]) begin
            written <= 1'b1; glyph <= cur.glyph; colour <= cur.colour;
          end else begin
            written <= 1'b0; pixel_col <= '0; pixel_row <= '0;
            glyph <= '0; colour <= COLOUR_BLANK;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !cmd_ready) else $error("accept during clear");
  a_rw: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_WRITE) else $error("rmw broken");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result lost");
`endif
endmodule

// ===== design/point_project_zbuffer_plot.sv =====
// Perspective z-buffer plotter: one result word per input word. A plot word
// holds the front end through lighting, rotation, the restoring divider that forms
// the reciprocal depth, projection and hand-off; a plot on an unlit face, an unused
// face code or behind the eye skips the divider. The front takes no next word until
// its last one has been handed off, so it works on one word at a time. The queue
// registers each word and the cell stage then accepts, reads memory and writes,
// overlapping the next word's front work; read words outside the grid and dropped
// plots skip the memory read and write. After reset all SCREEN_COLS*SCREEN_ROWS cells
// (7200 by default) of the cell memory are swept clear before any word reaches it.
module point_project_zbuffer_plot import ppz_pkg::*; #(
  parameter int SCREEN_COLS = 120,
  parameter int SCREEN_ROWS = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [2:0]  face,
  input  logic signed [15:0] coord_u,
  input  logic signed [15:0] coord_v,
  input  logic signed [15:0] coord_w,
  input  logic        dark,
  input  logic [6:0]  cell_col,
  input  logic [5:0]  cell_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        written,
  output logic [6:0]  pixel_col,
  output logic [5:0]  pixel_row,
  output logic [3:0]  glyph,
  output logic [1:0]  colour
);
  logic signed [15:0] sin_a, cos_a, sin_b, cos_b;
  logic [7:0] scale_factor, eye_distance, offset_x, offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_a <= 16'sd0; cos_a <= 16'sd16384; sin_b <= 16'sd0; cos_b <= 16'sd16384;
      scale_factor <= 8'd40; eye_distance <= 8'd40;
      offset_x <= 8'd50; offset_y <= 8'd45;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIN_A: sin_a <= cfg_data;
        REG_COS_A: cos_a <= cfg_data;
        REG_SIN_B: sin_b <= cfg_data;
        REG_COS_B: cos_b <= cfg_data;
        REG_SCALE: scale_factor <= cfg_data[7:0];
        REG_EYE:   eye_distance <= cfg_data[7:0];
        REG_OFF_X: offset_x <= cfg_data[7:0];
        REG_OFF_Y: offset_y <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic     f_valid, f_ready, b_valid, b_ready;
  ppz_cmd_t f_cmd, b_cmd;

  ppz_front #(.SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .face, .coord_u, .coord_v, .coord_w,
    .dark, .cell_col, .cell_row, .sin_a, .cos_a, .sin_b, .cos_b, .scale_factor,
    .eye_distance, .offset_x, .offset_y,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

  ppz_queue u_queue (.clk, .rst, .in_valid(f_valid), .in_ready(f_ready),
    .in_cmd(f_cmd), .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd));

  ppz_back #(.SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS)) u_back (
    .clk, .rst, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
    .out_valid, .out_ready, .written, .pixel_col, .pixel_row, .glyph, .colour);
endmodule

// ===== bench/plot_checker.sv =====
// Checker for the z-buffer plotter: tracks config writes, predicts each result word
// from accepted input words, and compares field by field. Depends on ppz_pkg.
`timescale 1ns / 1ps
module plot_checker import ppz_pkg::*; #(
  parameter int COLS = 120,
  parameter int ROWS = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        op,
  input  logic [2:0]  face,
  input  logic signed [15:0] coord_u,
  input  logic signed [15:0] coord_v,
  input  logic signed [15:0] coord_w,
  input  logic        dark,
  input  logic [6:0]  cell_col,
  input  logic [5:0]  cell_row,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        written,
  input  logic [6:0]  pixel_col,
  input  logic [5:0]  pixel_row,
  input  logic [3:0]  glyph,
  input  logic [1:0]  colour,
  output int          fail_count,
  output int          pending
);
  localparam int CELLS = COLS * ROWS;

  typedef struct packed {
    logic       written;
    logic [6:0] col;
    logic [5:0] row;
    logic [3:0] glyph;
    logic [1:0] colour;
  } pixel_word_t;

  pixel_word_t expected_words[$];
  logic signed [15:0] sin_a, cos_a, sin_b, cos_b;
  logic [7:0] scale, eye, off_x, off_y;
  logic [15:0] depth_mem[CELLS];
  logic [5:0]  cell_mem[CELLS];

  function automatic pixel_word_t plot_point(logic op_i, logic [2:0] face_i,
      logic signed [15:0] u_i, logic signed [15:0] v_i, logic signed [15:0] w_i,
      logic dark_i, logic [6:0] c_i, logic [5:0] r_i);
    pixel_word_t res;
    longint sa, ca, sb, cb, u, v, w, lit, g, x22, s22, y36, z36, y22, z22;
    longint den, ooz, px, py, one38;
    int idx;
    res = '0;
    if (op_i == OP_READ) begin
      res.col = c_i;
      res.row = r_i;
      if (c_i < COLS && r_i < ROWS) begin
        idx = r_i * COLS + c_i;
        res.glyph = cell_mem[idx][3:0];
        res.colour = cell_mem[idx][5:4];
        cell_mem[idx] = '0;
        depth_mem[idx] = '0;
      end
      return res;
    end
    sa = sin_a; ca = cos_a; sb = sin_b; cb = cos_b;
    case (face_i)
      FACE_BACK:   lit = -ca * cb;
      FACE_FRONT:  lit = ca * cb;
      FACE_RIGHT:  lit = -sa * cb;
      FACE_LEFT:   lit = sa * cb;
      FACE_TOP:    lit = sb * 16384;
      FACE_BOTTOM: lit = -sb * 16384;
      default:     return res;
    endcase
    if (lit <= 0) return res;
    g = (lit * 11) >>> 28;
    if (g > 11) g = 11;
    u = u_i; v = v_i; w = w_i;
    if (face_i == FACE_BACK || face_i == FACE_FRONT) begin
      x22 = u * ca + w * sa;
      s22 = u * sa - w * ca;
      y36 = v * cb * 16384 + s22 * sb;
      z36 = s22 * cb - v * sb * 16384;
    end else if (face_i == FACE_RIGHT || face_i == FACE_LEFT) begin
      x22 = w * ca - v * sa;
      s22 = w * sa + v * ca;
      y36 = u * cb * 16384 + s22 * sb;
      z36 = s22 * cb - u * sb * 16384;
    end else begin
      x22 = u * ca - v * sa;
      s22 = u * sa + v * ca;
      y36 = w * cb * 16384 + s22 * sb;
      z36 = s22 * cb - w * sb * 16384;
    end
    y22 = y36 >>> 14;  // arithmetic shift floors
    z22 = z36 >>> 14;
    den = z22 + (longint'(eye) <<< 22);
    if (den <= 0) return res;
    one38 = longint'(1) <<< 38;
    ooz = one38 / den;
    if (ooz > 65535) ooz = 65535;
    // division truncates toward zero, as the block does
    px = (longint'(scale) * ooz * x22 + (longint'(off_x) <<< 38)) / one38;
    py = (longint'(scale) * ooz * y22 + (longint'(off_y) <<< 38)) / one38;
    if (px < 0 || px >= COLS || py < 0 || py >= ROWS) return res;
    idx = int'(py) * COLS + int'(px);
    if (ooz <= longint'(depth_mem[idx])) return res;
    res.written = 1'b1;
    res.col = px[6:0];
    res.row = py[5:0];
    res.glyph = g[3:0];
    res.colour = dark_i ? COLOUR_GREY : COLOUR_GREEN;
    depth_mem[idx] = ooz[15:0];
    cell_mem[idx] = {res.colour, res.glyph};
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_word_t exp_w;
    if (rst) begin
      sin_a = 0; cos_a = 16384; sin_b = 0; cos_b = 16384;
      scale = 40; eye = 40; off_x = 50; off_y = 45;
      for (int i = 0; i < CELLS; i++) begin
        depth_mem[i] = '0;
        cell_mem[i] = '0;
      end
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SIN_A: sin_a = cfg_data;
          REG_COS_A: cos_a = cfg_data;
          REG_SIN_B: sin_b = cfg_data;
          REG_COS_B: cos_b = cfg_data;
          REG_SCALE: scale = cfg_data[7:0];
          REG_EYE:   eye = cfg_data[7:0];
          REG_OFF_X: off_x = cfg_data[7:0];
          REG_OFF_Y: off_y = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (written !== exp_w.written) begin
            $error("written: expected %0d got %0d", exp_w.written, written);
            fail_count++;
          end
          if (pixel_col !== exp_w.col) begin
            $error("pixel_col: expected %0d got %0d", exp_w.col, pixel_col);
            fail_count++;
          end
          if (pixel_row !== exp_w.row) begin
            $error("pixel_row: expected %0d got %0d", exp_w.row, pixel_row);
            fail_count++;
          end
          if (glyph !== exp_w.glyph) begin
            $error("glyph: expected %0d got %0d", exp_w.glyph, glyph);
            fail_count++;
          end
          if (colour !== exp_w.colour) begin
            $error("colour: expected %0d got %0d", exp_w.colour, colour);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        exp_w = plot_point(op, face, coord_u, coord_v, coord_w, dark, cell_col,
                           cell_row);
        expected_words.insert(expected_words.size(), exp_w);
      end
    end
    pending = expected_words.size();
  end
endmodule

// ===== bench/testbench.sv =====
// Top of the plotter bench: clock, reset, config phases and input/output traffic.
// Depends on ppz_pkg, point_project_zbuffer_plot and plot_checker.
`timescale 1ns / 1ps
module testbench;
  import ppz_pkg::*;

  localparam int IDLE_LIMIT = 40000;  // covers the post-reset clear sweep
  localparam int PHASE_WORDS = 205;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready, op, dark;
  logic [2:0] face;
  logic signed [15:0] coord_u, coord_v, coord_w;
  logic [6:0] cell_col;
  logic [5:0] cell_row;
  logic out_valid, out_ready, written;
  logic [6:0] pixel_col;
  logic [5:0] pixel_row;
  logic [3:0] glyph;
  logic [1:0] colour;
  int fail_count, pending, idle_cycles;
  bit quiet, long_hold;

  point_project_zbuffer_plot dut (.*);
  plot_checker u_checker (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic op_i, logic [2:0] face_i, logic [15:0] u_i,
      logic [15:0] v_i, logic [15:0] w_i, logic dark_i, logic [6:0] c_i, logic [5:0] r_i);
    if (!quiet && !long_hold && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    op = op_i; face = face_i; coord_u = u_i; coord_v = v_i; coord_w = w_i;
    dark = dark_i; cell_col = c_i; cell_row = r_i;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] cube_coord();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 6000)) - 3000);
  endfunction

  task automatic random_word();
    logic [6:0] c;
    logic [5:0] r;
    if ($urandom_range(0, 6) == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        c = 7'($urandom); r = 6'($urandom);
      end else begin
        c = 7'($urandom_range(25, 75)); r = 6'($urandom_range(20, 59));
      end
      send_word(OP_READ, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                1'($urandom), c, r);
    end else begin
      send_word(OP_PLOT, ($urandom_range(0, 20) == 0) ? 3'($urandom_range(6, 7))
                : 3'($urandom_range(0, 5)), cube_coord(), cube_coord(), cube_coord(),
                1'($urandom), 7'($urandom), 6'($urandom));
    end
  endtask

  task automatic angle_pair(output logic [15:0] s, output logic [15:0] c);
    case ($urandom_range(0, 5))
      0: begin s = 16'sd0;      c = 16'sd16384;  end
      1: begin s = 16'sd11585;  c = 16'sd11585;  end
      2: begin s = 16'sd16384;  c = 16'sd0;      end
      3: begin s = -16'sd11585; c = -16'sd11585; end
      4: begin s = 16'sd6270;   c = 16'sd15137;  end
      default: begin s = -16'sd6270; c = 16'sd15137; end
    endcase
  endtask

  task automatic set_phase(int p);
    logic [15:0] sa, ca, sb, cb;
    logic [7:0] k1, k2, ox, oy;
    angle_pair(sa, ca);
    angle_pair(sb, cb);
    k1 = 8'($urandom_range(20, 80)); k2 = 8'($urandom_range(20, 80));
    ox = 8'($urandom_range(30, 80)); oy = 8'($urandom_range(20, 50));
    case (p)
      1: begin k1 = 8'd255; k2 = 8'd255; ox = 8'd0; oy = 8'd0; end
      2: begin k1 = 8'd0; k2 = 8'd0; ox = 8'd255; oy = 8'd255; end
      3: begin sa = 16'h8000; ca = 16'h7FFF; sb = 16'h7FFF; cb = 16'h8000; end
      4: begin sa = -16'sd16384; ca = 16'sd16384; sb = 16'sd16384; cb = -16'sd16384; end
      default: ;
    endcase
    cfg_write(REG_SIN_A, sa);
    cfg_write(REG_COS_A, ca);
    cfg_write(REG_SIN_B, sb);
    cfg_write(REG_COS_B, cb);
    // upper bits of the byte-wide registers are ignored by the block
    cfg_write(REG_SCALE, {8'($urandom), k1});
    cfg_write(REG_EYE, {8'($urandom), k2});
    cfg_write(REG_OFF_X, {8'($urandom), ox});
    cfg_write(REG_OFF_Y, {8'($urandom), oy});
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; op = OP_PLOT; face = FACE_FRONT; dark = 1'b0;
    coord_u = '0; coord_v = '0; coord_w = '0; cell_col = '0; cell_row = '0;
    quiet = 1'b0; long_hold = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed words at reset settings
    send_word(OP_PLOT, FACE_FRONT, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0, '0);
    send_word(OP_PLOT, FACE_FRONT, 16'sd0, 16'sd0, 16'sd0, 1'b1, '0, '0);   // depth lost
    send_word(OP_PLOT, FACE_FRONT, 16'sd0, 16'sd0, -16'sd2560, 1'b1, '0, '0); // farther
    send_word(OP_READ, FACE_BACK, '0, '0, '0, 1'b0, 7'd50, 6'd45);
    send_word(OP_READ, FACE_BACK, '0, '0, '0, 1'b0, 7'd50, 6'd45);
    send_word(OP_PLOT, FACE_BACK, 16'sd256, 16'sd256, 16'sd256, 1'b0, '0, '0);
    send_word(OP_PLOT, FACE_RIGHT, 16'sd256, 16'sd256, 16'sd256, 1'b0, '0, '0);
    send_word(OP_PLOT, FACE_TOP, 16'sd256, 16'sd256, 16'sd256, 1'b0, '0, '0);
    send_word(OP_PLOT, 3'd6, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0, '0);
    send_word(OP_PLOT, 3'd7, 16'sd0, 16'sd0, 16'sd0, 1'b1, '0, '0);
    send_word(OP_PLOT, FACE_FRONT, 16'sd0, 16'sd0, 16'sd32767, 1'b0, '0, '0);  // behind eye
    send_word(OP_PLOT, FACE_FRONT, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, '0, '0);
    send_word(OP_PLOT, FACE_FRONT, 16'sd32767, 16'sd32767, -16'sd32768, 1'b1, '0, '0);
    send_word(OP_PLOT, FACE_FRONT, 16'sd2560, -16'sd2560, 16'sd0, 1'b1, '0, '0);
    send_word(OP_READ, FACE_BACK, '1, '1, '1, 1'b1, 7'd127, 6'd63);  // outside the grid
    send_word(OP_READ, FACE_BACK, '0, '0, '0, 1'b0, 7'd119, 6'd59);
    send_word(OP_READ, FACE_BACK, '0, '0, '0, 1'b0, 7'd0, 6'd0);
    send_word(OP_READ, FACE_BACK, '0, '0, '0, 1'b0, 7'd120, 6'd45);
    send_word(OP_READ, FACE_BACK, '0, '0, '0, 1'b0, 7'd50, 6'd60);
    repeat (PHASE_WORDS) random_word();

    for (int p = 1; p <= 7; p++) begin
      in_valid = 1'b0;
      wait_idle();
      set_phase(p);
      if (p == 5) long_hold = 1'b1;  // input fills up behind a blocked output
      if (p == 7) quiet = 1'b1;
      repeat (PHASE_WORDS) random_word();
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sim.f =====
design/ppz_pkg.sv
design/ppz_front.sv
design/ppz_queue.sv
design/ppz_back.sv
design/point_project_zbuffer_plot.sv
bench/plot_checker.sv
bench/testbench.sv
